@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled while reset is held
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

@@ rtl/pbrd_pkg.sv @@
// ----------------------------------------------------------------------------
// pbrd_pkg
// Types and constants of the PackBits row decoder.
// ----------------------------------------------------------------------------
package pbrd_pkg;

  localparam int BYTE_W  = 8;
  localparam int PITCH_W = 15;
  localparam int TOTAL_W = 16;
  localparam int LEFT_W  = 18;
  localparam int CFG_W   = 16;
  localparam int IDX_W   = 1;

  typedef logic [BYTE_W-1:0]  byte_t;
  typedef logic [PITCH_W-1:0] pitch_t;
  typedef logic [TOTAL_W-1:0] total_t;
  typedef logic [LEFT_W-1:0]  left_t;
  typedef logic [CFG_W-1:0]   cfg_data_t;
  typedef logic [IDX_W-1:0]   cfg_idx_t;

  // register indexes on the configuration port
  localparam cfg_idx_t REG_ROW_PITCH = 1'b0;
  localparam cfg_idx_t REG_ROW_TOTAL = 1'b1;

  // pitch above this uses a two-byte row count
  localparam pitch_t PITCH_SHORT_MAX = 15'd250;
  // run length is RUN_BASE minus the code byte
  localparam logic [BYTE_W:0] RUN_BASE = 9'd257;
  localparam byte_t CODE_RUN_BIT = 8'h80;

  localparam pitch_t PITCH_RESET = '0;
  localparam total_t TOTAL_RESET = 16'd1;

endpackage

@@ rtl/packbits_row_decoder.sv @@
// ----------------------------------------------------------------------------
// packbits_row_decoder
// Decodes a PackBits pixel stream, one byte per cycle, into (pixel, repeat)
// pairs. Each row starts with a one-byte count (pitch up to 250) or a two-byte
// big-endian count. A byte is taken in every cycle in which in_stall is low;
// in_stall rises only while a finished result sits in the output register and
// out_stall holds it. A result appears in the output register on the cycle
// after the byte that causes it. A run or literal byte gives one result, a row
// count of zero gives an empty-row marker with repeat_count 0, code and count
// bytes give none. Write row_pitch and row_total only while the block is idle.
// ----------------------------------------------------------------------------
module packbits_row_decoder (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  pbrd_pkg::byte_t   in_packed_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output pbrd_pkg::byte_t   out_pixel_value,
  output pbrd_pkg::byte_t   out_repeat_count,
  output logic              out_row_end,
  output logic              out_image_end,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  pbrd_pkg::cfg_idx_t  cfg_index,
  input  pbrd_pkg::cfg_data_t cfg_data
);
  import pbrd_pkg::*;

  typedef enum logic [2:0] {
    PH_LEN, PH_LEN_LO, PH_CODE, PH_RUN, PH_LIT
  } phase_t;

  phase_t phase_r, phase_nxt;
  byte_t  length_high_r, length_high_nxt;
  left_t  left_r, left_nxt;
  byte_t  literal_left_r, literal_left_nxt;
  byte_t  run_length_r, run_length_nxt;
  total_t rows_done_r, rows_done_nxt;
  pitch_t row_pitch_r;
  total_t row_total_r;

  logic   out_valid_r;
  byte_t  out_pixel_r, out_repeat_r;
  logic   out_row_end_r, out_image_end_r;

  logic   in_acc;
  logic   emit;
  byte_t  res_pix, res_rep;
  logic   res_row_end, res_img;
  logic   start, row_done;
  total_t count;
  total_t done_inc;
  byte_t  lit_dec;
  logic   left_le_zero;

  assign in_stall  = out_valid_r & out_stall;
  assign in_acc    = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;

  assign left_le_zero = left_r[LEFT_W-1] | (left_r == '0);
  assign lit_dec      = literal_left_r - byte_t'(1);
  assign done_inc     = rows_done_r + total_t'(1);

  always_comb begin
    phase_nxt        = phase_r;
    length_high_nxt  = length_high_r;
    left_nxt         = left_r;
    literal_left_nxt = literal_left_r;
    run_length_nxt   = run_length_r;
    rows_done_nxt    = rows_done_r;
    emit             = 1'b0;
    res_pix          = in_packed_byte;
    res_rep          = byte_t'(1);
    res_row_end      = 1'b0;
    res_img          = 1'b0;
    start            = 1'b0;
    count            = {{(TOTAL_W-BYTE_W){1'b0}}, in_packed_byte};
    row_done         = 1'b0;

    unique case (phase_r)
      PH_LEN_LO: begin
        start = 1'b1;
        count = {length_high_r, in_packed_byte};
      end
      PH_CODE: begin
        if ((in_packed_byte & CODE_RUN_BIT) != '0) begin
          run_length_nxt = BYTE_W'(RUN_BASE - {1'b0, in_packed_byte});
          left_nxt       = left_r - left_t'(2);
          phase_nxt      = PH_RUN;
        end else begin
          literal_left_nxt = in_packed_byte + byte_t'(1);
          left_nxt         = left_r - left_t'(in_packed_byte) - left_t'(2);
          phase_nxt        = PH_LIT;
        end
      end
      PH_RUN: begin
        emit        = 1'b1;
        res_rep     = run_length_r;
        res_row_end = left_le_zero;
        phase_nxt   = PH_CODE;
      end
      PH_LIT: begin
        literal_left_nxt = lit_dec;
        emit             = 1'b1;
        if (lit_dec == '0) begin
          phase_nxt   = PH_CODE;
          res_row_end = left_le_zero;
        end
      end
      default: begin
        if (row_pitch_r <= PITCH_SHORT_MAX) begin
          start = 1'b1;
        end else begin
          length_high_nxt = in_packed_byte;
          phase_nxt       = PH_LEN_LO;
        end
      end
    endcase

    if (start) begin
      left_nxt = left_t'(count);
      if (count == '0) begin
        emit        = 1'b1;
        res_pix     = '0;
        res_rep     = '0;
        res_row_end = 1'b1;
      end else begin
        phase_nxt = PH_CODE;
      end
    end

    row_done = emit & res_row_end;
    if (row_done) begin
      res_img       = (done_inc == row_total_r);
      rows_done_nxt = res_img ? '0 : done_inc;
      phase_nxt     = PH_LEN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_LEN;
      length_high_r  <= '0;
      left_r         <= '0;
      literal_left_r <= '0;
      run_length_r   <= '0;
      rows_done_r    <= '0;
      row_pitch_r    <= PITCH_RESET;
      row_total_r    <= TOTAL_RESET;
      out_valid_r    <= 1'b0;
    end else begin
      if (in_acc) begin
        phase_r        <= phase_nxt;
        length_high_r  <= length_high_nxt;
        left_r         <= left_nxt;
        literal_left_r <= literal_left_nxt;
        run_length_r   <= run_length_nxt;
        rows_done_r    <= rows_done_nxt;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_ROW_PITCH: row_pitch_r <= cfg_data[PITCH_W-1:0];
          REG_ROW_TOTAL: row_total_r <= cfg_data[TOTAL_W-1:0];
          default: ;
        endcase
      end
      if (!out_valid_r || !out_stall) begin
        out_valid_r <= in_acc & emit;
      end
    end
  end

  // result payload, loaded only when the register is free or draining
  always_ff @(posedge clk) begin
    if (in_acc && emit) begin
      out_pixel_r     <= res_pix;
      out_repeat_r    <= res_rep;
      out_row_end_r   <= res_row_end;
      out_image_end_r <= res_img;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_value  = out_pixel_r;
  assign out_repeat_count = out_repeat_r;
  assign out_row_end      = out_row_end_r;
  assign out_image_end    = out_image_end_r;

endmodule

@@ rtl/pbrd_checker.sv @@
// ----------------------------------------------------------------------------
// pbrd_checker
// Port-level checks of the PackBits row decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pbrd_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input pbrd_pkg::byte_t     out_pixel_value,
  input pbrd_pkg::byte_t     out_repeat_count,
  input logic                out_row_end,
  input logic                out_image_end
);
  import pbrd_pkg::*;

  // a held result keeps its place
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
  `ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall,
    $stable(out_pixel_value) && $stable(out_repeat_count))
  // input side backs up whenever a result is held
  `ASSERT_SAME(a_backpressure, clk, rst_n, out_valid && out_stall, in_stall)
  `ASSERT_SAME(a_img_row, clk, rst_n, out_valid && out_image_end, out_row_end)
  // empty-row marker always closes a row
  `ASSERT_SAME(a_empty_row, clk, rst_n, out_valid && (out_repeat_count == '0), out_row_end)

endmodule

bind packbits_row_decoder pbrd_checker u_pbrd_checker (.*);
